// ----- rtl/core/pip_pkg.sv -----
// Shared types and constants for the point-in-polygon test block.
// Used by pip_ctrl, pip_dpath and point_in_polygon_test; depends on nothing.
`default_nettype none

package pip_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned IdxW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned CntW = $clog2(MaxVertices + 1);
  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned ProdW = 2 * DiffW;

  typedef enum logic [1:0] {
    OpClear  = 2'd0,
    OpAppend = 2'd1,
    OpTest   = 2'd2
  } op_e;

  // Controller to datapath.
  typedef struct packed {
    logic clr_cnt;     // empty the vertex table
    logic wr_en;       // store the incoming vertex and bump the count
    logic load_point;  // capture the test point and start a new walk
    logic rd_en;       // read the next vertex of the walk
    logic close;       // inject the closing edge back to the first vertex
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic rd_last;     // the read about to be issued is of the last vertex
    logic busy;        // edges still travelling through the pipeline
    logic parity;      // running crossing parity
  } sts_t;

  // True when the signed-magnitude value p is strictly below q.
  function automatic logic signed_mag_lt(input logic pn, input logic [ProdW-1:0] pm,
                                         input logic qn, input logic [ProdW-1:0] qm);
    logic pneg;
    logic qneg;
    logic res;
    pneg = pn && (pm != '0);
    qneg = qn && (qm != '0);
    if (pneg != qneg) begin
      res = pneg;
    end else if (!pneg) begin
      res = (pm < qm);
    end else begin
      res = (pm > qm);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pip_ctrl.sv -----
// Controller of the point-in-polygon test block: sequencing and result register.
// Depends on pip_pkg for the opcode, command and status types.
`default_nettype none

module pip_ctrl
  import pip_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       inside_res_o,
  output logic       empty_area_o,
  output logic       table_full_o,
  output cmd_t       cmd_o,
  input  sts_t       sts_i
);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StRead   = 5'b00010,
    StClose  = 5'b00100,
    StDrain  = 5'b01000,
    StFinish = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   res_test_q, res_test_d;
  logic   res_empty_q, res_empty_d;
  logic   res_full_q, res_full_d;
  logic   out_valid_q, out_valid_d;
  logic   out_inside_q, out_inside_d;
  logic   out_empty_q, out_empty_d;
  logic   out_full_q, out_full_d;
  logic   slot_free;
  op_e    op;

  assign op = op_e'(opcode_i);
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    res_test_d   = res_test_q;
    res_empty_d  = res_empty_q;
    res_full_d   = res_full_q;
    out_valid_d  = out_valid_q;
    out_inside_d = out_inside_q;
    out_empty_d  = out_empty_q;
    out_full_d   = out_full_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          res_test_d  = 1'b0;
          res_empty_d = 1'b0;
          res_full_d  = 1'b0;
          state_d     = StFinish;
          case (op)
            OpClear: begin
              cmd_o.clr_cnt = 1'b1;
            end
            OpAppend: begin
              if (sts_i.cnt_full) begin
                res_full_d = 1'b1;
              end else begin
                cmd_o.wr_en = 1'b1;
              end
            end
            OpTest: begin
              if (sts_i.cnt_zero) begin
                res_empty_d = 1'b1;
              end else begin
                cmd_o.load_point = 1'b1;
                res_test_d       = 1'b1;
                state_d          = StRead;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.rd_last) begin
          state_d = StClose;
        end
      end
      StClose: begin
        cmd_o.close = 1'b1;
        state_d     = StDrain;
      end
      StDrain: begin
        if (!sts_i.busy) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_inside_d = res_test_q && sts_i.parity;
          out_empty_d  = res_empty_q;
          out_full_d   = res_full_q;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_test_q   <= res_test_d;
    res_empty_q  <= res_empty_d;
    res_full_q   <= res_full_d;
    out_inside_q <= out_inside_d;
    out_empty_q  <= out_empty_d;
    out_full_q   <= out_full_d;
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = out_inside_q;
  assign empty_area_o = out_empty_q;
  assign table_full_o = out_full_q;

endmodule

`default_nettype wire

// ----- rtl/core/pip_dpath.sv -----
// Datapath of the point-in-polygon test block: vertex memory, edge walk and
// the three-stage crossing test. Depends on pip_pkg for widths and types.
`default_nettype none

module pip_dpath
  import pip_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [CoordW-1:0] coord_lon_i,
  input  logic signed [CoordW-1:0] coord_lat_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o
);

  // Vertex memory, latitude in the upper half and longitude in the lower.
  logic [2*CoordW-1:0] vtx_mem_q [MaxVertices];
  logic [2*CoordW-1:0] rd_data_q;
  logic [CntW-1:0]     count_q;
  logic [IdxW-1:0]     rd_addr_q;

  logic signed [CoordW-1:0] px_q, py_q;

  // Walk stage.
  logic                rv_q, rfirst_q, close_q;
  logic [2*CoordW-1:0] first_q, prev_q, cur;
  logic                edge_v;

  // Stage one: differences and magnitudes.
  logic signed [CoordW-1:0] x0, y0, x1, y1;
  logic signed [DiffW-1:0]  dx, dl, dt, dd;
  logic [DiffW-1:0]         dx_mag, dl_mag, t_mag, d_mag;
  logic                     straddle;
  logic                     e1_v_q, e1_st_q, e1_dxn_q, e1_dln_q;
  logic [DiffW-1:0]         e1_dxm_q, e1_dlm_q, e1_tm_q, e1_dm_q;

  // Stage two: products.
  logic                     e2_v_q, e2_st_q, e2_dxn_q, e2_dln_q;
  logic [ProdW-1:0]         e2_lhs_q, e2_rhs_q;
  logic                     inside_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      vtx_mem_q[count_q[IdxW-1:0]] <= {coord_lat_i, coord_lon_i};
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= vtx_mem_q[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_addr_q <= '0;
      rv_q      <= 1'b0;
      rfirst_q  <= 1'b0;
      close_q   <= 1'b0;
      e1_v_q    <= 1'b0;
      e2_v_q    <= 1'b0;
      inside_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_cnt) begin
        count_q <= '0;
      end else if (cmd_i.wr_en) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.load_point) begin
        rd_addr_q <= '0;
      end else if (cmd_i.rd_en) begin
        rd_addr_q <= rd_addr_q + IdxW'(1);
      end
      rv_q     <= cmd_i.rd_en;
      rfirst_q <= (rd_addr_q == '0);
      close_q  <= cmd_i.close;
      e1_v_q   <= edge_v;
      e2_v_q   <= e1_v_q;
      if (cmd_i.load_point) begin
        inside_q <= 1'b0;
      end else if (e2_v_q && e2_st_q &&
                   signed_mag_lt(e2_dxn_q, e2_lhs_q, e2_dln_q, e2_rhs_q)) begin
        inside_q <= !inside_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_point) begin
      px_q <= coord_lon_i;
      py_q <= coord_lat_i;
    end
    if (rv_q) begin
      prev_q <= rd_data_q;
      if (rfirst_q) begin
        first_q <= rd_data_q;
      end
    end
  end

  // An edge leaves the walk for every vertex after the first, and once more
  // for the edge that closes the polygon.
  assign edge_v = (rv_q && !rfirst_q) || close_q;
  assign cur    = close_q ? first_q : rd_data_q;

  assign x0 = prev_q[CoordW-1:0];
  assign y0 = prev_q[2*CoordW-1:CoordW];
  assign x1 = cur[CoordW-1:0];
  assign y1 = cur[2*CoordW-1:CoordW];

  assign straddle = ((y0 <= py_q) && (y1 > py_q)) || ((y1 <= py_q) && (y0 > py_q));

  assign dx = DiffW'(x1) - DiffW'(x0);
  assign dl = DiffW'(px_q) - DiffW'(x0);
  assign dt = DiffW'(py_q) - DiffW'(y0);
  assign dd = DiffW'(y1) - DiffW'(y0);

  // Flip both latitude terms together so the denominator is positive.
  assign dx_mag = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
  assign dl_mag = dl[DiffW-1] ? DiffW'(-dl) : DiffW'(dl);
  assign t_mag  = dd[DiffW-1] ? DiffW'(-dt) : DiffW'(dt);
  assign d_mag  = dd[DiffW-1] ? DiffW'(-dd) : DiffW'(dd);

  always_ff @(posedge clk_i) begin
    e1_st_q  <= straddle;
    e1_dxn_q <= dx[DiffW-1];
    e1_dln_q <= dl[DiffW-1];
    e1_dxm_q <= dx_mag;
    e1_dlm_q <= dl_mag;
    e1_tm_q  <= t_mag;
    e1_dm_q  <= d_mag;

    e2_st_q  <= e1_st_q;
    e2_dxn_q <= e1_dxn_q;
    e2_dln_q <= e1_dln_q;
    e2_lhs_q <= ProdW'(e1_dxm_q) * ProdW'(e1_tm_q);
    e2_rhs_q <= ProdW'(e1_dlm_q) * ProdW'(e1_dm_q);
  end

  assign sts_o.cnt_zero = (count_q == '0);
  assign sts_o.cnt_full = (count_q == CntW'(MaxVertices));
  assign sts_o.rd_last  = (CntW'(rd_addr_q) == (count_q - CntW'(1)));
  assign sts_o.busy     = rv_q || close_q || e1_v_q || e2_v_q;
  assign sts_o.parity   = inside_q;

endmodule

`default_nettype wire

// ----- rtl/core/point_in_polygon_test.sv -----
// Top level of the ray-casting point-in-polygon test block.
// Instantiates pip_ctrl and pip_dpath; depends on pip_pkg.
//
// Usage: one input channel (opcode_i, coord_lon_i, coord_lat_i) and one
// result channel (inside_res_o, empty_area_o, table_full_o), both with
// valid and ready; a transfer takes place on a rising edge with both high.
// Every input transfer yields exactly one result transfer, in order.
// Opcode clear empties the vertex table, append stores a vertex (or raises
// table_full when the table already holds all its vertices), and test walks
// every stored edge and reports whether the point lies inside the polygon.
// Clear, append, an unused opcode and a test on an empty table pass from
// the idle state through the finish state into the output register. A
// test on a table of N vertices reads one vertex per cycle from the single
// read port of the vertex memory, then injects the closing edge and drains
// the three stage crossing pipeline. Items are handled one at a time; the
// next input transfer is taken as soon as the result has been written into
// the output register, even if the receiver has not yet taken it.
// When the receiver stalls, the result is held in the output register and a
// following item completes its work, then waits until the register is free.
// Reset empties the vertex table and clears all handshakes; the vertex memory
// itself is not cleared, as only entries below the count are ever read.
`default_nettype none

module point_in_polygon_test
  import pip_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               opcode_i,
  input  logic signed [CoordW-1:0] coord_lon_i,
  input  logic signed [CoordW-1:0] coord_lat_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     inside_res_o,
  output logic                     empty_area_o,
  output logic                     table_full_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each item and owns the result register.
  pip_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inside_res_o (inside_res_o),
    .empty_area_o (empty_area_o),
    .table_full_o (table_full_o),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  // The datapath holds the vertex table and evaluates one edge per cycle.
  pip_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coord_lon_i (coord_lon_i),
    .coord_lat_i (coord_lat_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef SYNTHESIS
  // No edge may still be in flight while a new item can be taken.
  a_idle_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts.busy)
    else $error("edge pipeline busy while accepting input");

  // A vertex is never written beyond the end of the table.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_en |-> !sts.cnt_full)
    else $error("vertex write into a full table");

  // At most one result flag is raised for any item.
  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({inside_res_o, empty_area_o, table_full_o}))
    else $error("more than one result flag set");
`endif

endmodule

`default_nettype wire
